// ===== design/pbr_pkg.sv =====
// shared types and constants of the bounded pcg32 random block
// no dependencies; imported by pbr_ctrl, pbr_dp and pcg32_bounded_random_top
package pbr_pkg;

    localparam int STATE_W   = 64;
    localparam int VALUE_W   = 32;
    localparam int IN_DATA_W = 128;
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [STATE_W-1:0] LCG_MUL = 64'd6364136223846793005;
    localparam logic [STATE_W-1:0] LCG_INC = 64'd11634580027462260723;

    localparam int XSH_SHIFT = 18;
    localparam int XSH_LOW   = 27;
    localparam int ROT_LOW   = 59;

    typedef enum logic [1:0] {
        MUL_LO,
        MUL_CROSS_A,
        MUL_CROSS_B
    } t_mul_phase;

    typedef enum logic {
        DIV_SRC_ONES,
        DIV_SRC_RAND
    } t_div_src;

    typedef enum logic [1:0] {
        OUT_SEED,
        OUT_MIN,
        OUT_SUM
    } t_out_sel;

    typedef struct packed {
        logic       load_item;
        logic       load_seed;
        logic       div_start;
        t_div_src   div_src;
        logic       div_step;
        logic       mul_en;
        t_mul_phase mul_phase;
        logic       state_commit;
        logic       out_load;
        t_out_sel   out_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic bounds_equal;
        logic div_last;
        logic reject;
    } t_dp_status;

endpackage

// ===== design/pbr_dp.sv =====
// datapath: generator state, shared 32x32 multiplier, radix-4 remainder unit, result register
// depends on pbr_pkg
module pbr_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pbr_pkg::t_dp_cmd             i_cmd,
    input  logic [pbr_pkg::IN_DATA_W-1:0] i_tdata,
    output pbr_pkg::t_dp_status          o_status,
    output logic [pbr_pkg::VALUE_W-1:0]  o_value,
    output logic                         o_ack
);
    import pbr_pkg::*;

    logic [STATE_W-1:0]   r_state;
    logic [STATE_W-1:0]   n_state;
    logic [STATE_W-1:0]   r_mul_acc;
    logic [VALUE_W-1:0]   r_lo;
    logic [VALUE_W-1:0]   r_div_n;
    logic [VALUE_W-1:0]   r_div_rem;
    logic [VALUE_W-1:0]   r_div_quo;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [VALUE_W-1:0]   r_out_value;
    logic                 r_out_ack;

    logic [STATE_W-1:0] w_seed;
    logic [VALUE_W-1:0] w_in_lo;
    logic [VALUE_W-1:0] w_in_hi;
    logic [VALUE_W-1:0] w_op_a;
    logic [VALUE_W-1:0] w_op_b;
    logic [STATE_W-1:0] w_prod;
    logic [STATE_W-1:0] w_xsh;
    logic [VALUE_W-1:0] w_mixed;
    logic [STATE_W-1:0] w_rot_pair;
    logic [VALUE_W-1:0] w_rand;
    logic [VALUE_W-1:0] w_rem1;
    logic [VALUE_W-1:0] w_rem2;

    function automatic logic [VALUE_W-1:0] rem_bit(
        input logic [VALUE_W-1:0] rem,
        input logic               din,
        input logic [VALUE_W-1:0] div
    );
        logic [VALUE_W:0] t;
        t = {rem, din};
        if (t >= {1'b0, div}) begin
            t = t - {1'b0, div};
        end
        return t[VALUE_W-1:0];
    endfunction

    assign w_seed  = i_tdata[STATE_W-1:0];
    assign w_in_lo = i_tdata[STATE_W +: VALUE_W];
    assign w_in_hi = i_tdata[STATE_W+VALUE_W +: VALUE_W];

    // low 64 bits of state * mul from three 32x32 partial products
    assign w_op_a = (i_cmd.mul_phase == MUL_CROSS_B) ? r_state[STATE_W-1:VALUE_W]
                                                     : r_state[VALUE_W-1:0];
    assign w_op_b = (i_cmd.mul_phase == MUL_CROSS_A) ? LCG_MUL[STATE_W-1:VALUE_W]
                                                     : LCG_MUL[VALUE_W-1:0];
    assign w_prod = {{VALUE_W{1'b0}}, w_op_a} * {{VALUE_W{1'b0}}, w_op_b};

    // xsh-rr output of the current state
    assign w_xsh      = (r_state >> XSH_SHIFT) ^ r_state;
    assign w_mixed    = w_xsh[XSH_LOW +: VALUE_W];
    assign w_rot_pair = {w_mixed, w_mixed} >> r_state[STATE_W-1:ROT_LOW];
    assign w_rand     = w_rot_pair[VALUE_W-1:0];

    assign w_rem1 = rem_bit(r_div_rem, r_div_quo[VALUE_W-1], r_div_n);
    assign w_rem2 = rem_bit(w_rem1, r_div_quo[VALUE_W-2], r_div_n);

    always_comb begin
        n_state = r_state;
        if (i_cmd.load_seed) begin
            n_state = w_seed;
        end else if (i_cmd.state_commit) begin
            n_state = r_mul_acc + LCG_INC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_lo <= w_in_lo;
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_phase)
                MUL_LO: begin
                    r_mul_acc <= w_prod;
                end
                MUL_CROSS_A, MUL_CROSS_B: begin
                    r_mul_acc[STATE_W-1:VALUE_W] <= r_mul_acc[STATE_W-1:VALUE_W]
                                                  + w_prod[VALUE_W-1:0];
                end
                default: begin
                    r_mul_acc <= r_mul_acc;
                end
            endcase
        end
        if (i_cmd.div_start) begin
            r_div_rem <= '0;
            r_div_cnt <= DIV_CNT_W'(DIV_STEPS - 1);
            if (i_cmd.div_src == DIV_SRC_ONES) begin
                r_div_quo <= '1;
                r_div_n   <= w_in_hi - w_in_lo;
            end else begin
                r_div_quo <= w_rand;
            end
        end else if (i_cmd.div_step) begin
            r_div_rem <= w_rem2;
            r_div_quo <= {r_div_quo[VALUE_W-3:0], 2'b00};
            r_div_cnt <= r_div_cnt - 1'b1;
        end
        if (i_cmd.out_load) begin
            case (i_cmd.out_sel)
                OUT_SEED: begin
                    r_out_value <= '0;
                    r_out_ack   <= 1'b1;
                end
                OUT_MIN: begin
                    r_out_value <= r_lo;
                    r_out_ack   <= 1'b0;
                end
                default: begin
                    r_out_value <= r_lo + r_div_rem;
                    r_out_ack   <= 1'b0;
                end
            endcase
        end
    end

    // cutoff is all-ones minus the remainder, i.e. its complement
    assign o_status.bounds_equal = (w_in_lo == w_in_hi);
    assign o_status.div_last     = (r_div_cnt == '0);
    assign o_status.reject       = (w_rand > ~r_div_rem);

    assign o_value = r_out_value;
    assign o_ack   = r_out_ack;

endmodule

// ===== design/pbr_ctrl.sv =====
// controller: sequences seed loads, lcg steps, rejection and remainder passes
// depends on pbr_pkg; drives pbr_dp through t_dp_cmd
module pbr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_action,
    output logic                o_s_tready,
    input  logic                i_m_tready,
    output logic                o_m_tvalid,
    input  pbr_pkg::t_dp_status i_status,
    output pbr_pkg::t_dp_cmd    o_cmd
);
    import pbr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_CUT,
        S_STEP_LO,
        S_STEP_CA,
        S_STEP_CB,
        S_STEP_ADD,
        S_CHECK,
        S_DIV_MOD,
        S_FINISH
    } t_state;

    t_state   r_state;
    t_state   n_state;
    t_out_sel r_kind;
    t_out_sel n_kind;
    logic     r_out_valid;
    logic     n_out_valid;
    logic     w_accept;
    t_dp_cmd  w_cmd;

    assign w_accept = i_s_tvalid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        w_cmd   = '0;
        w_cmd.mul_phase = MUL_LO;
        w_cmd.div_src   = DIV_SRC_ONES;
        w_cmd.out_sel   = r_kind;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_cmd.load_item = 1'b1;
                    if (i_action) begin
                        w_cmd.load_seed = 1'b1;
                        n_kind  = OUT_SEED;
                        n_state = S_FINISH;
                    end else if (i_status.bounds_equal) begin
                        n_kind  = OUT_MIN;
                        n_state = S_FINISH;
                    end else begin
                        w_cmd.div_start = 1'b1;
                        n_state = S_DIV_CUT;
                    end
                end
            end
            S_DIV_CUT: begin
                w_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_STEP_LO;
                end
            end
            S_STEP_LO: begin
                w_cmd.mul_en = 1'b1;
                n_state = S_STEP_CA;
            end
            S_STEP_CA: begin
                w_cmd.mul_en    = 1'b1;
                w_cmd.mul_phase = MUL_CROSS_A;
                n_state = S_STEP_CB;
            end
            S_STEP_CB: begin
                w_cmd.mul_en    = 1'b1;
                w_cmd.mul_phase = MUL_CROSS_B;
                n_state = S_STEP_ADD;
            end
            S_STEP_ADD: begin
                w_cmd.state_commit = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_status.reject) begin
                    n_state = S_STEP_LO;
                end else begin
                    w_cmd.div_start = 1'b1;
                    w_cmd.div_src   = DIV_SRC_RAND;
                    n_state = S_DIV_MOD;
                end
            end
            S_DIV_MOD: begin
                w_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_kind  = OUT_SUM;
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_m_tready) begin
                    w_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = w_cmd.out_load || (r_out_valid && !i_m_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= OUT_SEED;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_cmd      = w_cmd;

    a_seed_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_action |=> (r_state == S_FINISH) && (r_kind == OUT_SEED))
        else $error("seed item did not go straight to finish");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> r_out_valid)
        else $error("result loaded but not presented");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!r_out_valid || i_m_tready))
        else $error("pending result overwritten");

    a_cut_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_CUT) && i_status.div_last |=> (r_state == S_STEP_LO))
        else $error("cutoff pass did not hand over to the generator");

endmodule

// ===== design/pcg32_bounded_random_top.sv =====
// bounded pcg32 random block, top level
// depends on pbr_pkg, pbr_ctrl and pbr_dp
//
// input word: s_axis_tuser selects the action (0 draw, 1 load seed);
// s_axis_tdata carries seed, min and max. a draw returns a value in
// [min, max) on m_axis_tdata with m_axis_tuser low; equal bounds return min.
// a seed word loads the 64-bit generator state and returns zero with
// m_axis_tuser high.
// one word is in flight at a time. seed and equal-bound words go from
// acceptance straight to the finish state. a draw runs a cutoff remainder
// pass, k generator steps (k being the number of steps until an output
// passes the cutoff, usually 1) and a result remainder pass; both passes
// take 2 bits per cycle; each step uses one shared 32x32 multiplier.
// the result register lets the next word be accepted while a result waits;
// a stalled receiver holds the result and the next result waits inside.
// reset clears the generator state to zero and empties the result register.
module pcg32_bounded_random_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // seed_value[63:0], range_min[95:64], range_max[127:96]
    input  logic [pbr_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // action[0]
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // random_value[31:0]
    output logic [pbr_pkg::VALUE_W-1:0]   m_axis_tdata,
    // seed_ack[0]
    output logic                          m_axis_tuser
);
    import pbr_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    pbr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_action   (s_axis_tuser),
        .o_s_tready (s_axis_tready),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    pbr_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_tdata  (s_axis_tdata),
        .o_status (w_status),
        .o_value  (m_axis_tdata),
        .o_ack    (m_axis_tuser)
    );

endmodule
